// ===== design/bts_pkg.sv =====
// Package for the BCD timestamp gap block: stamp and control types,
// calendar constants and BCD/month helper functions. No dependencies.

package bts_pkg;

   // widths of intermediate values
   localparam int DAY_W = 16;   // day count since 2000, worst case with bad BCD
   localparam int TOD_W = 18;   // seconds within a day, unchecked fields
   localparam int SEC_W = 33;   // seconds since 2000, worst case with bad BCD
   localparam int GAP_W = 32;

   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [1:0]  LEAP_MASK     = 2'b11;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [3:0]  MARCH_INDEX   = 4'd2;

   // one calendar stamp as delivered by the clock chip, all BCD
   typedef struct packed {
      logic [6:0] second;
      logic [6:0] minute;
      logic [5:0] hour;
      logic [5:0] day;
      logic [4:0] month;
      logic [7:0] year;
   } stamp_type;

   // stage load enables from the pipeline control to a lane
   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } lane_ctl_type;

   // tens*10 + units, no check on nibbles above nine
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] tens;
      logic [7:0] units;
      tens  = {4'b0000, b[7:4]};
      units = {4'b0000, b[3:0]};
      return (tens << 3) + (tens << 1) + units;
   endfunction

   // days before the first of a month, index 0 is January
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] d;
      case (mi)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

endpackage

// ===== design/bts_lane.sv =====
// One conversion lane: BCD stamp to seconds since 2000-01-01 00:00:00.
// Two registered stages (day count and time of day, then seconds). Uses bts_pkg.

module bts_lane (
   input  logic                         clock,
   input  bts_pkg::lane_ctl_type        ctl,
   input  bts_pkg::stamp_type           stamp,
   output logic [bts_pkg::SEC_W-1:0]    seconds
);
   import bts_pkg::*;

   logic [7:0]       sec_bin;
   logic [7:0]       min_bin;
   logic [7:0]       hour_bin;
   logic [7:0]       day_bin;
   logic [7:0]       month_bin;
   logic [7:0]       year_bin;
   logic [3:0]       mi;
   logic [5:0]       day_m1;
   logic [8:0]       year_p3;
   logic             leap_adj;
   logic [DAY_W-1:0] days_in;
   logic [DAY_W-1:0] days_ff;
   logic [TOD_W-1:0] tod_in;
   logic [TOD_W-1:0] tod_ff;
   logic [SEC_W-1:0] secs_in;
   logic [SEC_W-1:0] secs_ff;

   // stage 1: decode fields, clamp month and day, count days
   always_comb begin
      sec_bin   = bcd_value({1'b0, stamp.second});
      min_bin   = bcd_value({1'b0, stamp.minute});
      hour_bin  = bcd_value({2'b00, stamp.hour});
      day_bin   = bcd_value({2'b00, stamp.day});
      month_bin = bcd_value({3'b000, stamp.month});
      year_bin  = bcd_value(stamp.year);

      // month zero counts as January, above twelve as December
      if (month_bin == 8'd0) begin
         mi = 4'd0;
      end else if (month_bin > 8'd12) begin
         mi = 4'd11;
      end else begin
         mi = 4'(month_bin - 8'd1);
      end

      // day zero counts as day one
      day_m1 = (day_bin == 8'd0) ? 6'd0 : 6'(day_bin - 8'd1);

      // leap days in the years before this one, plus this year's if past February
      year_p3  = {1'b0, year_bin} + 9'd3;
      leap_adj = ((year_bin[1:0] & LEAP_MASK) == 2'b00) && (mi >= MARCH_INDEX);

      days_in = DAY_W'(year_bin) * DAY_W'(DAYS_PER_YEAR)
              + DAY_W'(month_start(mi))
              + DAY_W'(day_m1)
              + DAY_W'(year_p3[8:2])
              + DAY_W'(leap_adj);

      tod_in = TOD_W'(hour_bin) * TOD_W'(SECS_PER_HOUR)
             + TOD_W'(min_bin) * TOD_W'(SECS_PER_MIN)
             + TOD_W'(sec_bin);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   // stage 2: days to seconds
   assign secs_in = SEC_W'(days_ff) * SEC_W'(SECS_PER_DAY) + SEC_W'(tod_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         secs_ff <= secs_in;
      end
   end

   assign seconds = secs_ff;

endmodule

// ===== design/bts_merge.sv =====
// Merge stage: absolute difference of the two lane results, saturated to
// 32 bits, held in the output register. Uses bts_pkg.

module bts_merge (
   input  logic                         clock,
   input  logic                         load,
   input  logic [bts_pkg::SEC_W-1:0]    secs_a,
   input  logic [bts_pkg::SEC_W-1:0]    secs_b,
   output logic [bts_pkg::GAP_W-1:0]    gap
);
   import bts_pkg::*;

   logic [SEC_W-1:0] diff;
   logic [GAP_W-1:0] gap_in;
   logic [GAP_W-1:0] gap_ff;

   // magnitude of the difference, clipped when it needs the top bit
   always_comb begin
      diff   = (secs_a >= secs_b) ? (secs_a - secs_b) : (secs_b - secs_a);
      gap_in = diff[SEC_W-1] ? {GAP_W{1'b1}} : diff[GAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gap_ff <= gap_in;
      end
   end

   assign gap = gap_ff;

endmodule

// ===== design/bcd_timestamp_gap.sv =====
// Top level of the BCD timestamp gap block: two conversion lanes and a merge stage.
// Depends on bts_pkg, bts_lane and bts_merge.
// Path: an accepted item passes the day count, seconds and difference registers to rsp_valid.
// Throughput: one item per cycle; the three-stage pipeline stalls only on rsp_ready.
// Reset: synchronous, clears the stage valid bits; the pipeline comes up empty.

module bcd_timestamp_gap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_first_second,
   input  logic [6:0]  req_first_minute,
   input  logic [5:0]  req_first_hour,
   input  logic [5:0]  req_first_day,
   input  logic [4:0]  req_first_month,
   input  logic [7:0]  req_first_year,
   input  logic [6:0]  req_second_second,
   input  logic [6:0]  req_second_minute,
   input  logic [5:0]  req_second_hour,
   input  logic [5:0]  req_second_day,
   input  logic [4:0]  req_second_month,
   input  logic [7:0]  req_second_year,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_gap_seconds
);
   import bts_pkg::*;

   stamp_type        stamp_a;
   stamp_type        stamp_b;
   lane_ctl_type     lane_ctl;
   logic [SEC_W-1:0] secs_a;
   logic [SEC_W-1:0] secs_b;
   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   logic             vo_ff, vo_in;
   logic             rdy1, rdy2, rdy_o;
   logic             load_o;

   assign stamp_a = '{second: req_first_second, minute: req_first_minute,
                      hour: req_first_hour, day: req_first_day,
                      month: req_first_month, year: req_first_year};
   assign stamp_b = '{second: req_second_second, minute: req_second_minute,
                      hour: req_second_hour, day: req_second_day,
                      month: req_second_month, year: req_second_year};

   // a stage moves on when it is empty or its successor moves on
   always_comb begin
      rdy_o = !vo_ff || rsp_ready;
      rdy2  = !v2_ff || rdy_o;
      rdy1  = !v1_ff || rdy2;

      lane_ctl.load_s1 = rdy1 && req_valid;
      lane_ctl.load_s2 = rdy2 && v1_ff;
      load_o           = rdy_o && v2_ff;

      v1_in = rdy1  ? req_valid : v1_ff;
      v2_in = rdy2  ? v1_ff     : v2_ff;
      vo_in = rdy_o ? v2_ff     : vo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         vo_ff <= vo_in;
      end
   end

   // one lane per stamp
   bts_lane u_lane_a (
      .clock   (clock),
      .ctl     (lane_ctl),
      .stamp   (stamp_a),
      .seconds (secs_a)
   );

   bts_lane u_lane_b (
      .clock   (clock),
      .ctl     (lane_ctl),
      .stamp   (stamp_b),
      .seconds (secs_b)
   );

   bts_merge u_merge (
      .clock  (clock),
      .load   (load_o),
      .secs_a (secs_a),
      .secs_b (secs_b),
      .gap    (rsp_gap_seconds)
   );

   assign req_ready = rdy1;
   assign rsp_valid = vo_ff;

   // an empty pipeline always takes an item
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !vo_ff) |-> req_ready)
      else $error("empty pipeline refuses an item");

   // an accepted item lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted item lost at stage 1");

   // a stage 2 item blocked downstream is kept
   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy_o) |=> (v2_ff && vo_ff))
      else $error("stalled stage 2 item dropped");

   // with the sink ready throughout, an accepted item passes stage 1, stage 2 and the output register to rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item not delivered after three cycles");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for bcd_timestamp_gap: directed and random pairs of BCD stamps,
// with the expected gap in seconds computed in the bench. Depends on bts_pkg (stamp_type)
// and the bcd_timestamp_gap RTL.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bts_pkg::*;

   localparam int DAYS_IN_YEAR    = 365;
   localparam int SECS_IN_DAY     = 86400;
   localparam int SECS_IN_HOUR    = 3600;
   localparam int SECS_IN_MIN     = 60;
   localparam int RANDOM_ITEMS    = 500;
   localparam int HOLD_AT         = 50;    // accepted count that starts the long hold
   localparam int LONG_HOLD       = 60;    // cycles rsp_ready stays low
   localparam int CALM_FROM       = 200;
   localparam int CALM_TO         = 260;
   localparam int DRAIN_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int MAX_REPORTS     = 40;

   // one pair of stamps waiting to be offered
   typedef struct {
      stamp_type first;
      stamp_type second;
      int        idle_before;
      bit        drain_first;
   } stamp_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [6:0]  req_first_second = '0;
   logic [6:0]  req_first_minute = '0;
   logic [5:0]  req_first_hour = '0;
   logic [5:0]  req_first_day = '0;
   logic [4:0]  req_first_month = '0;
   logic [7:0]  req_first_year = '0;
   logic [6:0]  req_second_second = '0;
   logic [6:0]  req_second_minute = '0;
   logic [5:0]  req_second_hour = '0;
   logic [5:0]  req_second_day = '0;
   logic [4:0]  req_second_month = '0;
   logic [7:0]  req_second_year = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_gap_seconds;

   stamp_pair_type pair_q[$];
   logic [31:0] gap_expect_q[$];
   int          n_offered = 0;
   int          n_accepted = 0;
   int          n_total = 0;
   int          fail_count = 0;
   int          idle_left = 0;
   int          ready_stall = 0;
   bit          long_hold_done = 1'b0;
   int          quiet_cycles = 0;

   bcd_timestamp_gap DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_second  (req_first_second),
      .req_first_minute  (req_first_minute),
      .req_first_hour    (req_first_hour),
      .req_first_day     (req_first_day),
      .req_first_month   (req_first_month),
      .req_first_year    (req_first_year),
      .req_second_second (req_second_second),
      .req_second_minute (req_second_minute),
      .req_second_hour   (req_second_hour),
      .req_second_day    (req_second_day),
      .req_second_month  (req_second_month),
      .req_second_year   (req_second_year),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gap_seconds   (rsp_gap_seconds)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic longint unsigned bcd_to_bin(input logic [7:0] b);
      return longint'(b[7:4]) * 10 + longint'(b[3:0]);
   endfunction

   function automatic int month_length(input int m);
      if (m == 2) return 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   // seconds since 2000-01-01 00:00:00, no checks on the BCD digits
   function automatic longint unsigned seconds_since_2000(input stamp_type s);
      longint unsigned sec, mnt, hr, dy, mon, yr, days;
      sec = bcd_to_bin({1'b0, s.second});
      mnt = bcd_to_bin({1'b0, s.minute});
      hr  = bcd_to_bin({2'b00, s.hour});
      dy  = bcd_to_bin({2'b00, s.day});
      mon = bcd_to_bin({3'b000, s.month});
      yr  = bcd_to_bin(s.year);
      // month zero reads as January, anything past December as December
      if (mon == 0) mon = 1;
      if (mon > 12) mon = 12;
      if (dy == 0) dy = 1;
      // leap days of the years before this one, every fourth year from 00
      days = yr * DAYS_IN_YEAR + (dy - 1) + (yr + 3) / 4;
      for (int m = 1; m < mon; m++) days += month_length(m);
      if (yr % 4 == 0 && mon > 2) days += 1;
      return days * SECS_IN_DAY + hr * SECS_IN_HOUR + mnt * SECS_IN_MIN + sec;
   endfunction

   function automatic logic [31:0] stamp_gap(input stamp_type a, input stamp_type b);
      longint unsigned ta, tb, d;
      ta = seconds_since_2000(a);
      tb = seconds_since_2000(b);
      d  = (ta >= tb) ? ta - tb : tb - ta;
      if (d > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return d[31:0];
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] to_bcd(input int v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   function automatic stamp_type make_stamp(input logic [7:0] sec, input logic [7:0] mnt,
                                            input logic [7:0] hr, input logic [7:0] dy,
                                            input logic [7:0] mon, input logic [7:0] yr);
      stamp_type s;
      s.second = sec[6:0];
      s.minute = mnt[6:0];
      s.hour   = hr[5:0];
      s.day    = dy[5:0];
      s.month  = mon[4:0];
      s.year   = yr;
      return s;
   endfunction

   function automatic stamp_type random_date();
      return make_stamp(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
                        to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(1, 31)),
                        to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(0, 99)));
   endfunction

   function automatic stamp_type random_bits();
      logic [63:0] r;
      stamp_type   s;
      r = {$urandom(), $urandom()};
      s = r[38:0];
      return s;
   endfunction

   // same stamp with one field replaced, so the pair differs in at most one field
   function automatic stamp_type nudge(input stamp_type s);
      stamp_type t;
      logic [7:0] v;
      t = s;
      case ($urandom_range(0, 5))
         0: begin v = to_bcd($urandom_range(0, 59)); t.second = v[6:0]; end
         1: begin v = to_bcd($urandom_range(0, 59)); t.minute = v[6:0]; end
         2: begin v = to_bcd($urandom_range(0, 23)); t.hour = v[5:0]; end
         3: begin v = to_bcd($urandom_range(1, 31)); t.day = v[5:0]; end
         4: begin v = to_bcd($urandom_range(1, 12)); t.month = v[4:0]; end
         default: begin t.year = to_bcd($urandom_range(0, 99)); end
      endcase
      return t;
   endfunction

   task automatic add_pair(input stamp_type a, input stamp_type b, input bit drain);
      int k;
      int idle;
      k = pair_q.size();
      // back-to-back windows around the long receiver hold and the calm stretch
      if ((k >= 40 && k < 140) || (k >= 195 && k < 275)) idle = 0;
      else idle = pick_idle();
      pair_q.push_back('{first: a, second: b, idle_before: idle, drain_first: drain});
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : driver
      stamp_pair_type item;
      bit waiting;
      if (!reset) begin
         waiting = req_valid && (n_accepted != n_offered);
         if (!waiting) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pair_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pair_q[0].drain_first && gap_expect_q.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               item = pair_q.pop_front();
               req_first_second  <= item.first.second;
               req_first_minute  <= item.first.minute;
               req_first_hour    <= item.first.hour;
               req_first_day     <= item.first.day;
               req_first_month   <= item.first.month;
               req_first_year    <= item.first.year;
               req_second_second <= item.second.second;
               req_second_minute <= item.second.minute;
               req_second_hour   <= item.second.hour;
               req_second_day    <= item.second.day;
               req_second_month  <= item.second.month;
               req_second_year   <= item.second.year;
               req_valid <= 1'b1;
               n_offered++;
               if (pair_q.size() != 0) idle_left = pair_q[0].idle_before;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (!long_hold_done && n_accepted >= HOLD_AT) begin
            long_hold_done = 1'b1;
            ready_stall = LONG_HOLD;
         end
         if (ready_stall > 0) begin
            ready_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (n_accepted < CALM_FROM || n_accepted >= CALM_TO) ready_stall = pick_idle();
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      stamp_type   a;
      stamp_type   b;
      logic [31:0] want;
      bit          moved;
      if (!reset) begin
         moved = 1'b0;
         // compare each result with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (gap_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: gap_seconds expected none, actual %0d", $time, rsp_gap_seconds);
            end else begin
               want = gap_expect_q.pop_front();
               if (rsp_gap_seconds !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: gap_seconds expected %0d, actual %0d",
                              $time, want, rsp_gap_seconds);
               end
            end
         end
         // predict from what was actually on the request ports
         if (req_valid && req_ready) begin
            moved = 1'b1;
            a = '{second: req_first_second, minute: req_first_minute, hour: req_first_hour,
                  day: req_first_day, month: req_first_month, year: req_first_year};
            b = '{second: req_second_second, minute: req_second_minute, hour: req_second_hour,
                  day: req_second_day, month: req_second_month, year: req_second_year};
            gap_expect_q.push_back(stamp_gap(a, b));
            n_accepted++;
         end
         // watchdog on cycles with no item moving on either side
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : stimulus
      stamp_type zero_stamp;
      stamp_type ones_stamp;
      stamp_type top_stamp;
      stamp_type x;
      stamp_type y;
      int        r;
      zero_stamp = make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
      ones_stamp = make_stamp(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF);
      top_stamp  = make_stamp(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);

      // directed: extremes, leap handling, clamped month and day, bad nibbles
      add_pair('0, '0, 1'b0);
      add_pair(top_stamp, zero_stamp, 1'b0);
      add_pair(zero_stamp, top_stamp, 1'b0);
      add_pair(make_stamp(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h04),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h04), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h01),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h00), 1'b0);
      add_pair(make_stamp(8'h12, 8'h34, 8'h05, 8'h15, 8'h00, 8'h21),
               make_stamp(8'h12, 8'h34, 8'h05, 8'h15, 8'h01, 8'h21), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h10, 8'h13, 8'h44),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h10, 8'h12, 8'h44), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h10, 8'h1F, 8'h45),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h10, 8'h06, 8'h45), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h05, 8'h10, 8'h08),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h05, 8'h0A, 8'h08), 1'b0);
      add_pair(make_stamp(8'h30, 8'h30, 8'h12, 8'h00, 8'h07, 8'h50),
               make_stamp(8'h30, 8'h30, 8'h12, 8'h01, 8'h07, 8'h50), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h3F, 8'h02, 8'h12),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h12), 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h33),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h05, 8'h33), 1'b0);
      add_pair(make_stamp(8'h7F, 8'h7F, 8'h3F, 8'h01, 8'h01, 8'h00), zero_stamp, 1'b0);
      add_pair(ones_stamp, '0, 1'b0);
      add_pair('0, ones_stamp, 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9F), zero_stamp, 1'b0);
      add_pair(make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0), zero_stamp, 1'b0);
      add_pair(make_stamp(8'h45, 8'h17, 8'h08, 8'h19, 8'h09, 8'h67),
               make_stamp(8'h45, 8'h17, 8'h08, 8'h19, 8'h09, 8'h67), 1'b0);
      add_pair(make_stamp(8'h0A, 8'h0F, 8'h1A, 8'h0C, 8'h03, 8'h0E),
               make_stamp(8'h10, 8'h15, 8'h20, 8'h12, 8'h03, 8'h14), 1'b0);
      add_pair(make_stamp(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h03),
               make_stamp(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h04), 1'b0);

      // random: mostly real dates, some near pairs, some raw bit patterns
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            x = random_date();
            y = random_date();
         end else if (r < 75) begin
            x = random_date();
            y = nudge(x);
         end else if (r < 90) begin
            x = random_bits();
            y = random_bits();
         end else begin
            x = random_bits();
            y = random_date();
         end
         if ($urandom_range(0, 1) == 1) add_pair(x, y, i == 0 || i == 300);
         else add_pair(y, x, i == 0 || i == 300);
      end
      n_total = pair_q.size();

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while (n_accepted != n_total || gap_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && gap_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bts_pkg.sv
design/bts_lane.sv
design/bts_merge.sv
design/bcd_timestamp_gap.sv
dv/tb_top.sv
